>>> rtl/core/lic_pkg.sv
`default_nettype none

package lic_pkg;

    // Width of the millisecond clock and of every deadline
    localparam int TIME_BITS   = 32;
    // Number of filtered indicators (num, caps, scroll), at most 3
    localparam int NUM_TRACKED = 3;

    localparam int SPAN_BITS = 16;
    localparam int LED_BITS  = 5;
    localparam int CH_MAX    = 3;

    // Reset values of the configuration registers
    localparam logic [SPAN_BITS-1:0] KEY_WINDOW_RESET  = 16'd20;
    localparam logic [SPAN_BITS-1:0] PERSIST_RESET     = 16'd1000;
    localparam logic [2:0]           TRACKED_RESET     = 3'd7;
    localparam logic [1:0]           PASSTHROUGH_RESET = 2'd3;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_KEY_WINDOW  = 2'd0;
    localparam logic [1:0] REG_PERSIST     = 2'd1;
    localparam logic [1:0] REG_TRACKED     = 2'd2;
    localparam logic [1:0] REG_PASSTHROUGH = 2'd3;

    // Bits of the compose and kana indicators
    localparam int LED_COMPOSE = 3;
    localparam int LED_KANA    = 4;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_KEY    = 2'd1,
        MODE_SAMPLE = 2'd2
    } mode_t;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef struct packed {
        logic [SPAN_BITS-1:0] key_window_ms;
        logic [SPAN_BITS-1:0] persist_ms;
        logic [2:0]           tracked_mask;
        logic [1:0]           passthrough_mask;
    } lic_cfg_t;

    // Timers of one filtered indicator, zero meaning stopped
    typedef struct packed {
        time_t window_deadline;
        time_t persist_deadline;
    } lic_chan_t;

    // Deadline a span after now; a sum that wraps to zero becomes 1
    function automatic time_t lic_start(input time_t now, input logic [SPAN_BITS-1:0] span);
        time_t d;
        d = now + {{(TIME_BITS-SPAN_BITS){1'b0}}, span};
        if (d == '0) begin
            d = time_t'(1);
        end
        return d;
    endfunction

    // Wrap-aware expiry: now - deadline has its top bit clear
    function automatic logic lic_expired(input time_t now, input time_t deadline);
        time_t diff;
        diff = now - deadline;
        return ~diff[TIME_BITS-1];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/lic_cfg_regs.sv
`default_nettype none

module lic_cfg_regs
    import lic_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output lic_cfg_t         cfg
);

    lic_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    // Register writes on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.key_window_ms    <= KEY_WINDOW_RESET;
            cfg_reg.persist_ms       <= PERSIST_RESET;
            cfg_reg.tracked_mask     <= TRACKED_RESET;
            cfg_reg.passthrough_mask <= PASSTHROUGH_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_KEY_WINDOW:  cfg_reg.key_window_ms    <= pwdata[SPAN_BITS-1:0];
                REG_PERSIST:     cfg_reg.persist_ms       <= pwdata[SPAN_BITS-1:0];
                REG_TRACKED:     cfg_reg.tracked_mask     <= pwdata[2:0];
                REG_PASSTHROUGH: cfg_reg.passthrough_mask <= pwdata[1:0];
            endcase
        end
    end

    // Read-back
    always_comb begin
        unique case (reg_idx)
            REG_KEY_WINDOW:  prdata = {16'd0, cfg_reg.key_window_ms};
            REG_PERSIST:     prdata = {16'd0, cfg_reg.persist_ms};
            REG_TRACKED:     prdata = {29'd0, cfg_reg.tracked_mask};
            REG_PASSTHROUGH: prdata = {30'd0, cfg_reg.passthrough_mask};
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/lic_channel.sv
`default_nettype none

module lic_channel
    import lic_pkg::*;
(
    input  wire time_t                  now,
    input  wire logic [SPAN_BITS-1:0]   key_window_ms,
    input  wire logic [SPAN_BITS-1:0]   persist_ms,
    input  wire logic [1:0]             mode,
    input  wire logic                   key_hit,
    input  wire logic                   tracked,
    input  wire logic                   host_bit,
    input  wire logic                   acc_bit,
    input  wire lic_chan_t              chan,
    output lic_chan_t                   chan_next,
    output logic                        acc_next
);

    // Next timers and accepted bit of one filtered indicator
    always_comb begin
        time_t win;
        time_t per;
        logic  acc;
        win = chan.window_deadline;
        per = chan.persist_deadline;
        acc = acc_bit;
        if (tracked && mode == MODE_KEY && key_hit) begin
            // key press opens the window and stops persistence
            win = lic_start(now, key_window_ms);
            per = '0;
        end else if (tracked && mode == MODE_SAMPLE) begin
            if (win != '0) begin
                if (!lic_expired(now, win)) begin
                    acc = host_bit;
                end else begin
                    win = '0;
                end
            end
            if (win == '0) begin
                if (host_bit != acc) begin
                    if (per == '0) begin
                        per = lic_start(now, persist_ms);
                    end else if (lic_expired(now, per)) begin
                        acc = host_bit;
                        per = '0;
                    end
                end else begin
                    per = '0;
                end
            end
        end
        chan_next.window_deadline  = win;
        chan_next.persist_deadline = per;
        acc_next                   = acc;
    end

endmodule

`default_nettype wire

>>> rtl/core/lock_indicator_change_filter.sv
`default_nettype none

// Channel   Ports            Content
// input     s_axis_*         tuser: mode; tdata: key_indicator, host_leds
// result    m_axis_*         tdata: filtered_leds
// config    APB p*           key_window_ms, persist_ms, tracked_mask, passthrough_mask
//
// One item per cycle while the result is not stalled; each item passes the input
// register, which feeds the filter logic, and then the result register. The filter
// state updates as the item moves into the result register; the next item sees it.
// Synchronous active-low reset clears the clock, all timers and the indicators.
// A stalled result holds its register; one more item may wait in the input stage.

module lock_indicator_change_filter
    import lic_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [1:0] key_indicator, [6:2] host_leds
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata,  // [4:0] filtered_leds
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    lic_cfg_t cfg;

    // Input stage
    logic                in_valid_reg;
    logic [1:0]          mode_reg;
    logic [1:0]          key_reg;
    logic [LED_BITS-1:0] host_reg;

    // Result stage
    logic                out_valid_reg;
    logic [LED_BITS-1:0] out_leds_reg;

    // Filter state
    time_t               time_reg;
    time_t               time_next;
    lic_chan_t           chan_reg  [NUM_TRACKED];
    lic_chan_t           chan_next [NUM_TRACKED];
    logic [LED_BITS-1:0] acc_reg;
    logic [LED_BITS-1:0] acc_next;

    logic in_xfer;
    logic advance;

    lic_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: the input stage moves on whenever the result stage is free
    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;
    assign in_xfer       = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            mode_reg <= s_axis_tuser;
            key_reg  <= s_axis_tdata[1:0];
            host_reg <= s_axis_tdata[6:2];
        end
    end

    // Millisecond clock
    assign time_next = (mode_reg == MODE_TICK) ? time_reg + time_t'(1) : time_reg;

    // Filtered indicators
    for (genvar i = 0; i < NUM_TRACKED; i++) begin : g_chan
        lic_channel u_chan (
            .now           (time_reg),
            .key_window_ms (cfg.key_window_ms),
            .persist_ms    (cfg.persist_ms),
            .mode          (mode_reg),
            .key_hit       (key_reg == 2'(i)),
            .tracked       (cfg.tracked_mask[i]),
            .host_bit      (host_reg[i]),
            .acc_bit       (acc_reg[i]),
            .chan          (chan_reg[i]),
            .chan_next     (chan_next[i]),
            .acc_next      (acc_next[i])
        );
    end

    // Indicators beyond the filtered set keep their bits
    for (genvar i = NUM_TRACKED; i < CH_MAX; i++) begin : g_hold
        assign acc_next[i] = acc_reg[i];
    end

    // Compose and kana pass-through on a host sample, each when its passthrough_mask bit is set
    assign acc_next[LED_COMPOSE] = (mode_reg == MODE_SAMPLE && cfg.passthrough_mask[0])
                                   ? host_reg[LED_COMPOSE] : acc_reg[LED_COMPOSE];
    assign acc_next[LED_KANA]    = (mode_reg == MODE_SAMPLE && cfg.passthrough_mask[1])
                                   ? host_reg[LED_KANA] : acc_reg[LED_KANA];

    // State update as the item leaves the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
            acc_reg  <= '0;
            for (int i = 0; i < NUM_TRACKED; i++) begin
                chan_reg[i] <= '0;
            end
        end else if (advance) begin
            time_reg <= time_next;
            acc_reg  <= acc_next;
            for (int i = 0; i < NUM_TRACKED; i++) begin
                chan_reg[i] <= chan_next[i];
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_leds_reg <= acc_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_leds_reg};

endmodule

`default_nettype wire
